// ===== design/bpe_pkg.sv =====
// Shared types, register codes and constants for the B-spline point evaluator.
package bpe_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COORD_W = 32;
	localparam int RECIP_SHIFT = 24;
	localparam int NUM_W = 19;

	// Configuration register indexes.
	localparam logic REG_TIME_SCALE = 1'b0;
	localparam logic REG_POINT_COUNT = 1'b1;

	// Item commands.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	typedef struct packed {
		logic cmd;
		logic [5:0] point_index;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic [31:0] sample_time;
	} item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} result_t;

	// Per-cycle controls from the sequencer to each coordinate lane.
	typedef struct packed {
		logic load;
		logic rot;
		logic blend;
		logic diff_en;
		logic mul_en;
	} lane_ctl_t;

	// Reciprocal floor(2^24 / d) for the small alpha divisors.
	function automatic logic [RECIP_SHIFT:0] recip(input logic [2:0] d);
		logic [RECIP_SHIFT:0] m;
		case (d)
			3'd1: m = 25'd16777216;
			3'd2: m = 25'd8388608;
			3'd3: m = 25'd5592405;
			3'd4: m = 25'd4194304;
			3'd5: m = 25'd3355443;
			default: m = 25'd16777216;
		endcase
		return m;
	endfunction

endpackage

// ===== design/bpe_ram.sv =====
// Generic simple dual-port RAM with a registered read.
module bpe_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 64
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/bpe_lane.sv =====
// One coordinate lane: de Boor work registers and the blend datapath.
module bpe_lane import bpe_pkg::*; #(
	parameter int DEGREE = 3
) (
	input  logic clk,
	input  lane_ctl_t ctl,
	input  logic signed [31:0] rdata,
	input  logic [FRAC_BITS:0] alpha,
	output logic signed [31:0] res
);

	logic signed [31:0] w_q [DEGREE+1];
	logic signed [32:0] diff_q;
	logic signed [50:0] mul_q;
	logic signed [52:0] sum;
	logic signed [36:0] shr;
	logic signed [31:0] blend_res;

	// Rounding, floor shift and saturation of the blended value.
	always_comb begin
		sum = {{5{w_q[DEGREE-1][31]}}, w_q[DEGREE-1], 16'b0}
			+ {{2{mul_q[50]}}, mul_q} + 53'sd32768;
		shr = sum[52:16];
		if (shr > 37'sd2147483647) begin
			blend_res = 32'sh7fffffff;
		end else if (shr < -37'sd2147483648) begin
			blend_res = 32'sh80000000;
		end else begin
			blend_res = shr[31:0];
		end
	end

	// Work registers rotate up; the bottom takes read data, the top register or a new blended value.
	always_ff @(posedge clk) begin
		if (ctl.load || ctl.rot || ctl.blend) begin
			for (int j = 1; j <= DEGREE; j++) begin
				w_q[j] <= w_q[j-1];
			end
			if (ctl.load) begin
				w_q[0] <= rdata;
			end else if (ctl.rot) begin
				w_q[0] <= w_q[DEGREE];
			end else begin
				w_q[0] <= blend_res;
			end
		end
		if (ctl.diff_en) begin
			diff_q <= {w_q[DEGREE][31], w_q[DEGREE]} - {w_q[DEGREE-1][31], w_q[DEGREE-1]};
		end
		if (ctl.mul_en) begin
			mul_q <= $signed({1'b0, alpha}) * diff_q;
		end
	end

	assign res = w_q[DEGREE];

endmodule

// ===== design/bspline_point_evaluator.sv =====
// Top level: command port, configuration, control point memory and de Boor sequencer.
//
// A transaction is accepted when start is high and busy is low. A write
// transaction (cmd = 0) stores one control point and gives
// no result. An evaluate transaction (cmd = 1) maps sample_time to the spline
// parameter, reads the DEGREE+1 control points of its span from the point
// memory one per cycle, and runs the de Boor triangle with one shared alpha
// unit and one blend lane per coordinate. Each blend steps through alpha
// multiply, alpha correction, blend multiply, and round and saturate;
// each de Boor level also spends a step rotating each untouched work register.
// Busy stays high from accept to result; the next transaction can be accepted
// in the cycle the result is shown. The result stands on result for one cycle
// with result_valid high; the receiver cannot stall it. Configuration is
// written through cfg_we, cfg_idx and cfg_wdata; the user must write it while
// the block is idle, which the block itself does not enforce. Reset sets
// time_scale to 1.0 and point_count to 64 and returns the sequencer to idle;
// the memory is not cleared and points must be written before they are used.
module bspline_point_evaluator import bpe_pkg::*; #(
	parameter int MAX_POINTS = 64,
	parameter int DEGREE = 3,
	parameter int DIMS = 3
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  item_t item,
	output logic result_valid,
	output result_t result,
	input  logic cfg_we,
	input  logic cfg_idx,
	input  logic [31:0] cfg_wdata
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int PCW = $clog2(MAX_POINTS + 1);
	localparam int CMPW = (PCW > 7) ? PCW : 7;
	localparam int UW = PCW + FRAC_BITS;
	localparam int MW = DIMS * COORD_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_SPAN, ST_KSEL, ST_RD, ST_RDW, ST_STEP, ST_B1, ST_B2, ST_B3
	} state_t;

	state_t state_q;
	logic [31:0] time_scale_q;
	logic [6:0] point_count_q;
	logic [63:0] prod_q;
	logic [UW-1:0] u_q;
	logic [AW-1:0] k_q;
	logic [2:0] cnt_q;
	logic [2:0] r_q;
	logic [2:0] s_q;
	logic rd_pend_q;
	logic [NUM_W-1:0] num_q;
	logic [NUM_W+RECIP_SHIFT:0] ap_q;
	logic [FRAC_BITS:0] alpha_q;
	logic result_valid_q;
	logic signed [31:0] pos_q [3];

	logic [CMPW-1:0] pc_raw;
	logic [PCW-1:0] pc;
	logic [48:0] u_full;
	logic [48:0] u_lim;
	logic [UW:0] ceil_u;
	logic [UW:0] k_full;
	logic [UW+1:0] knot;
	logic signed [UW+1:0] num_full;
	logic [NUM_W-1:0] num_clip;
	logic [2:0] dsr;
	logic [NUM_W:0] q0;
	logic signed [NUM_W+4:0] rem;
	logic [NUM_W:0] q1;
	logic active;
	logic ram_we;
	logic [AW-1:0] raddr;
	logic [MW-1:0] wdata;
	logic [MW-1:0] rdata;
	lane_ctl_t ctl;
	logic signed [31:0] lane_res [DIMS];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_scale_q <= 32'd65536;
			point_count_q <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_TIME_SCALE: time_scale_q <= cfg_wdata;
				REG_POINT_COUNT: point_count_q <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	// Point count clamp, parameter mapping and span selection.
	always_comb begin
		pc_raw = CMPW'(point_count_q);
		if (pc_raw < CMPW'(DEGREE + 1)) begin
			pc = PCW'(DEGREE + 1);
		end else if (pc_raw > CMPW'(MAX_POINTS)) begin
			pc = PCW'(MAX_POINTS);
		end else begin
			pc = PCW'(pc_raw);
		end
		u_full = {1'b0, prod_q[63:16]} + (49'(DEGREE) << FRAC_BITS);
		u_lim = 49'(pc) << FRAC_BITS;
		ceil_u = ({1'b0, u_q} + (UW+1)'(16'hffff)) >> FRAC_BITS;
		k_full = ceil_u - (UW+1)'(1);
		if (k_full < (UW+1)'(DEGREE)) begin
			k_full = (UW+1)'(DEGREE);
		end
	end

	// Alpha numerator and reciprocal correction.
	always_comb begin
		knot = (UW+2)'(k_q - AW'(s_q)) << FRAC_BITS;
		num_full = $signed({2'b0, u_q}) - $signed(knot);
		num_clip = num_full[UW+1] ? '0 : num_full[NUM_W-1:0];
		dsr = 3'(DEGREE + 1) - r_q;
		q0 = ap_q[NUM_W+RECIP_SHIFT:RECIP_SHIFT];
		rem = $signed({5'b0, num_q}) - $signed({4'b0, q0} * {2'b0, dsr});
		q1 = (rem >= $signed({(NUM_W+2)'(0), dsr})) ? q0 + 1'b1 : q0;
		active = s_q <= 3'(DEGREE) - r_q;
	end

	// Lane controls.
	always_comb begin
		ctl = '0;
		ctl.load = rd_pend_q;
		if (state_q == ST_STEP) begin
			ctl.diff_en = active;
			ctl.rot = !active;
		end
		ctl.mul_en = (state_q == ST_B2);
		ctl.blend = (state_q == ST_B3);
	end

	// Sequencer with its datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			r_q <= '0;
			s_q <= '0;
			rd_pend_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			rd_pend_q <= (state_q == ST_RD);
			unique case (state_q)
				ST_IDLE: begin
					if (start && item.cmd == CMD_EVAL) begin
						prod_q <= 64'(item.sample_time) * 64'(time_scale_q);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					u_q <= (u_full > u_lim) ? UW'(u_lim) : UW'(u_full);
					state_q <= ST_SPAN;
				end
				ST_SPAN: begin
					k_q <= AW'(k_full);
					cnt_q <= '0;
					state_q <= ST_KSEL;
				end
				ST_KSEL: begin
					state_q <= ST_RD;
				end
				ST_RD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 3'(DEGREE)) begin
						state_q <= ST_RDW;
					end
				end
				ST_RDW: begin
					r_q <= 3'd1;
					s_q <= '0;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (active) begin
						num_q <= num_clip;
						ap_q <= num_clip * recip(dsr);
						state_q <= ST_B1;
					end else if (s_q == 3'(DEGREE)) begin
						s_q <= '0;
						if (r_q == 3'(DEGREE)) begin
							result_valid_q <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							r_q <= r_q + 1'b1;
						end
					end else begin
						s_q <= s_q + 1'b1;
					end
				end
				ST_B1: begin
					alpha_q <= (q1 > (NUM_W+1)'(65536)) ? 17'd65536 : q1[FRAC_BITS:0];
					state_q <= ST_B2;
				end
				ST_B2: begin
					state_q <= ST_B3;
				end
				ST_B3: begin
					s_q <= s_q + 1'b1;
					state_q <= ST_STEP;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Point memory ports.
	assign ram_we = (state_q == ST_IDLE) && start && (item.cmd == CMD_WRITE)
		&& (32'(item.point_index) < 32'(MAX_POINTS));
	assign raddr = k_q - AW'(cnt_q);

	always_comb begin
		wdata = '0;
		wdata[COORD_W-1:0] = item.coord_x;
		if (DIMS > 1) begin
			wdata[(DIMS > 1 ? 1 : 0)*COORD_W +: COORD_W] = item.coord_y;
		end
		if (DIMS > 2) begin
			wdata[(DIMS > 2 ? 2 : 0)*COORD_W +: COORD_W] = item.coord_z;
		end
	end

	bpe_ram #(
		.WIDTH(MW),
		.DEPTH(MAX_POINTS)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(AW'(item.point_index)),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Coordinate lanes; unused dimensions read as zero.
	for (genvar d = 0; d < 3; d++) begin : g_dim
		if (d < DIMS) begin : g_lane
			bpe_lane #(
				.DEGREE(DEGREE)
			) u_lane (
				.clk(clk),
				.ctl(ctl),
				.rdata(rdata[d*COORD_W +: COORD_W]),
				.alpha(alpha_q),
				.res(lane_res[d])
			);
			assign pos_q[d] = lane_res[d];
		end else begin : g_zero
			assign pos_q[d] = '0;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result.pos_x = pos_q[0];
	assign result.pos_y = pos_q[1];
	assign result.pos_z = pos_q[2];

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the B-spline point evaluator.
`timescale 1ns / 100ps

module tb_top;
	import bpe_pkg::*;

	localparam int NPTS = 64;
	localparam int DEG = 3;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	item_t item = '0;
	logic result_valid;
	result_t result;
	logic cfg_we = 1'b0;
	logic cfg_idx = REG_TIME_SCALE;
	logic [31:0] cfg_wdata = '0;

	bspline_point_evaluator dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor state: its own copy of the registers and the point table.
	logic [31:0] scale_q;
	logic [6:0] count_q;
	logic signed [31:0] table_x [NPTS];
	logic signed [31:0] table_y [NPTS];
	logic signed [31:0] table_z [NPTS];

	item_t pending_items [$];
	result_t expected_pos [$];
	int errors = 0;
	int n_writes = 0;
	int n_evals = 0;
	int n_cfg = 0;
	int n_checked = 0;
	int idle_left = 0;
	bit burst = 1'b0;
	bit accepted = 1'b0;
	int quiet_cycles = 0;

	// One de Boor blend: convex mix, round half up, saturate.
	function automatic logic signed [31:0] mix_point(logic signed [31:0] lo,
			logic signed [31:0] hi, longint alpha);
		longint s;
		longint r;
		s = (65536 - alpha) * longint'(lo) + alpha * longint'(hi);
		r = (s + 32768) >>> 16;
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		return r[31:0];
	endfunction

	// Evaluate the spline position for one sample time.
	function automatic result_t spline_position(logic [31:0] t);
		longint unsigned pc;
		longint unsigned u;
		longint unsigned k;
		longint num;
		longint alpha;
		logic signed [31:0] wx [DEG+1];
		logic signed [31:0] wy [DEG+1];
		logic signed [31:0] wz [DEG+1];
		result_t res;
		pc = count_q;
		if (pc < DEG + 1)
			pc = DEG + 1;
		if (pc > NPTS)
			pc = NPTS;
		u = ((64'(t) * 64'(scale_q)) >> 16) + (64'(DEG) << 16);
		if (u > (pc << 16))
			u = pc << 16;
		k = ((u + 65535) >> 16) - 1;
		if (k < DEG)
			k = DEG;
		for (int i = 0; i <= DEG; i++) begin
			wx[i] = table_x[k - DEG + i];
			wy[i] = table_y[k - DEG + i];
			wz[i] = table_z[k - DEG + i];
		end
		for (int r = 1; r <= DEG; r++) begin
			for (int i = DEG; i >= r; i--) begin
				num = longint'(u) - longint'((k - DEG + i) << 16);
				if (num < 0)
					num = 0;
				alpha = num / (DEG + 1 - r);
				if (alpha > 65536)
					alpha = 65536;
				wx[i] = mix_point(wx[i-1], wx[i], alpha);
				wy[i] = mix_point(wy[i-1], wy[i], alpha);
				wz[i] = mix_point(wz[i-1], wz[i], alpha);
			end
		end
		res.pos_x = wx[DEG];
		res.pos_y = wy[DEG];
		res.pos_z = wz[DEG];
		return res;
	endfunction

	// Driver: presents queued transactions at the falling edge with random gaps.
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !accepted) begin
			end else if (idle_left > 0) begin
				start <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (pending_items.size() > 0) begin
				item <= pending_items.pop_front();
				start <= 1'b1;
				if ($urandom_range(0, 39) == 0)
					burst = !burst;
				idle_left <= burst ? 0 : $urandom_range(0, 13);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: accepts transactions and results at the rising edge and checks them.
	always @(posedge clk) begin
		result_t exp_r;
		accepted <= start && !busy && arst_n;
		if (arst_n) begin
			if (cfg_we) begin
				n_cfg++;
				if (cfg_idx == REG_TIME_SCALE)
					scale_q = cfg_wdata;
				else
					count_q = cfg_wdata[6:0];
			end
			if (result_valid) begin
				n_checked++;
				if (expected_pos.size() == 0) begin
					errors++;
					$display("%0t: unexpected result x=%h y=%h z=%h", $time,
						result.pos_x, result.pos_y, result.pos_z);
				end else begin
					exp_r = expected_pos.pop_front();
					if (result.pos_x !== exp_r.pos_x) begin
						errors++;
						$display("%0t: pos_x expected %h actual %h", $time,
							exp_r.pos_x, result.pos_x);
					end
					if (result.pos_y !== exp_r.pos_y) begin
						errors++;
						$display("%0t: pos_y expected %h actual %h", $time,
							exp_r.pos_y, result.pos_y);
					end
					if (result.pos_z !== exp_r.pos_z) begin
						errors++;
						$display("%0t: pos_z expected %h actual %h", $time,
							exp_r.pos_z, result.pos_z);
					end
				end
			end
			if (start && !busy) begin
				if (item.cmd == CMD_WRITE) begin
					n_writes++;
					table_x[item.point_index] = item.coord_x;
					table_y[item.point_index] = item.coord_y;
					table_z[item.point_index] = item.coord_z;
				end else begin
					n_evals++;
					expected_pos.insert(expected_pos.size(),
						spline_position(item.sample_time));
				end
			end
			// Watchdog on cycles with no accepted traffic.
			if ((start && !busy) || result_valid || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired", $time);
				$display("bspline_point_evaluator test failed");
				$finish;
			end
		end
	end

	function automatic item_t write_item(logic [5:0] idx, logic [31:0] x,
			logic [31:0] y, logic [31:0] z);
		item_t it;
		it = '0;
		it.cmd = CMD_WRITE;
		it.point_index = idx;
		it.coord_x = x;
		it.coord_y = y;
		it.coord_z = z;
		it.sample_time = $urandom;
		return it;
	endfunction

	function automatic item_t eval_item(logic [31:0] t);
		item_t it;
		it = '0;
		it.cmd = CMD_EVAL;
		it.point_index = 6'($urandom);
		it.coord_x = $urandom;
		it.coord_y = $urandom;
		it.coord_z = $urandom;
		it.sample_time = t;
		return it;
	endfunction

	// Coordinate with a bias toward extremes and small values.
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_time();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 4) << 16;
			default: return $urandom_range(0, 32'h0044_0000);
		endcase
	endfunction

	// Appends one transaction to the driver's queue.
	task automatic queue_item(item_t it);
		pending_items.insert(pending_items.size(), it);
	endtask

	// Waits until all queued work has drained and the block is idle.
	task automatic wait_idle();
		do @(posedge clk);
		while (pending_items.size() > 0 || start || expected_pos.size() > 0 || busy);
		repeat (45) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	logic [31:0] phase_scale [8] = '{32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF,
		32'h0000_4000, 32'h0002_8000, 32'h0000_8000, 32'h0001_0000, 32'h0000_1000};
	logic [6:0] phase_count [8] = '{7'd64, 7'd4, 7'd127, 7'd0, 7'd10, 7'd65, 7'd3, 7'd37};

	initial begin
		scale_q = 32'h0001_0000;
		count_q = 7'd64;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Fill the whole point table before anything is evaluated.
		for (int i = 0; i < NPTS; i++)
			queue_item(write_item(6'(i), rand_coord(), rand_coord(), rand_coord()));
		queue_item(write_item(6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
		queue_item(write_item(6'd63, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
		// Directed evaluations: ends of the time range, knots and midpoints.
		queue_item(eval_item(32'h0000_0000));
		queue_item(eval_item(32'hFFFF_FFFF));
		queue_item(eval_item(32'h0000_0001));
		queue_item(eval_item(32'h0001_0000));
		queue_item(eval_item(32'h0000_8000));
		queue_item(eval_item(32'h0001_FFFF));
		queue_item(eval_item(32'h003C_0000));
		queue_item(eval_item(32'h003C_0001));
		queue_item(eval_item(32'h003D_0000));
		queue_item(eval_item(32'h8000_0000));

		// Register settings in turn, with random traffic under each.
		for (int p = 0; p < 8; p++) begin
			wait_idle();
			write_reg(REG_TIME_SCALE, phase_scale[p]);
			write_reg(REG_POINT_COUNT, {25'h0, phase_count[p]});
			for (int n = 0; n < 240; n++) begin
				if ($urandom_range(0, 9) < 6)
					queue_item(eval_item(rand_time()));
				else
					queue_item(write_item(6'($urandom), rand_coord(),
						rand_coord(), rand_coord()));
			end
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d point writes, %0d evaluations (%0d results checked),",
			n_writes, n_evals, n_checked);
		$display("and %0d register writes across 8 scale and count settings.", n_cfg);
		if (errors == 0 && expected_pos.size() == 0)
			$display("bspline_point_evaluator test passed");
		else
			$display("bspline_point_evaluator test failed");
		$finish;
	end

endmodule
